>>> rtl/tcprr_pkg.sv
package tcprr_pkg;

  // Table and queue sizes
  localparam int CONN_DEPTH  = 16;
  localparam int QUEUE_DEPTH = 8;
  localparam int TAG_WIDTH   = 8;

  localparam int CONN_W  = (CONN_DEPTH > 1) ? $clog2(CONN_DEPTH) : 1;
  localparam int SLOT_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int QENT_W  = 32 + 16 + TAG_WIDTH;
  localparam int QADDR_W = CONN_W + SLOT_W;
  localparam int QRAM_DEPTH = CONN_DEPTH << SLOT_W;

  // Connection states
  typedef enum logic [1:0] {
    ST_CLOSED      = 2'd0,
    ST_OPENING     = 2'd1,
    ST_ESTABLISHED = 2'd2,
    ST_CLOSING     = 2'd3
  } tcprr_conn_t;

  // Result kinds
  localparam logic [2:0] KIND_IGNORED    = 3'd0;
  localparam logic [2:0] KIND_STORED     = 3'd1;
  localparam logic [2:0] KIND_DELIVERED  = 3'd2;
  localparam logic [2:0] KIND_QUEUE_FULL = 3'd3;
  localparam logic [2:0] KIND_TABLE_FULL = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOOKUP,
    S_UPDATE,
    S_DRAIN_RD,
    S_DRAIN_CHK,
    S_FIND_RD,
    S_FIND_CHK,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_INSERT,
    S_EMIT
  } tcprr_state_t;

  typedef struct packed {
    logic [31:0] source_address;
    logic [15:0] source_port;
    logic [31:0] dest_address;
    logic [15:0] dest_port;
    logic [31:0] seq_number;
    logic [15:0] payload_length;
    logic [15:0] window_size;
    logic        flag_syn;
    logic        flag_ack;
    logic        flag_fin;
    logic [7:0]  segment_tag;
  } tcprr_in_t;

  typedef struct packed {
    logic [2:0] result_kind;
    logic [7:0] delivered_tag;
    logic [3:0] connection_index;
    logic       last_result;
  } tcprr_out_t;

  // Ring slot of queue position k behind head
  function automatic logic [SLOT_W-1:0] slot_of(input logic [SLOT_W-1:0] head,
                                               input logic [COUNT_W-1:0] k);
    logic [SLOT_W+COUNT_W:0] sum;
    sum = (SLOT_W+COUNT_W+1)'(head) + (SLOT_W+COUNT_W+1)'(k);
    if (sum >= (SLOT_W+COUNT_W+1)'(QUEUE_DEPTH))
      sum = sum - (SLOT_W+COUNT_W+1)'(QUEUE_DEPTH);
    return sum[SLOT_W-1:0];
  endfunction

endpackage

>>> rtl/tcprr_ram.sv
module tcprr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/tcp_receive_reassembly.sv
// Channel | Direction | Handshake          | Payload
// in_     | input     | in_valid/in_stall  | tcprr_in_t (segment descriptor)
// out_    | output    | out_valid/out_stall| tcprr_out_t (one result)
// One segment at a time. Lookup walks the table one entry per cycle, up to
// CONN_DEPTH entries. Delivery reads, compares and emits a result for each
// queued segment; sorted insert reads and checks each entry searched, and
// reads and writes each entry shifted. Reset clears the connection valid bits
// and queue counts at once. A stalled result holds the block; in_stall is
// high until the last result.
module tcp_receive_reassembly
  import tcprr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  tcprr_in_t  in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output tcprr_out_t out_data
);

  // Sequencer and working registers
  tcprr_state_t state_r, state_nxt, ret_r, ret_nxt;
  tcprr_in_t    in_r;
  logic [CONN_W-1:0]    i_r, i_nxt, c_r, c_nxt, free_idx_r, free_idx_nxt;
  logic                 free_found_r, free_found_nxt;
  logic [31:0]          nxt_r, nxt_nxt;
  logic [TAG_WIDTH-1:0] ptag_r, ptag_nxt;
  logic [COUNT_W-1:0]   pos_r, pos_nxt, j_r, j_nxt;
  logic                 out_valid_r, out_valid_nxt;
  tcprr_out_t           out_r, out_nxt;

  // Connection table
  logic                 valid_r [CONN_DEPTH];
  logic [63:0]          addr_r  [CONN_DEPTH];
  logic [31:0]          ports_r [CONN_DEPTH];
  tcprr_conn_t          cstate_r[CONN_DEPTH];
  logic [31:0]          cnext_r [CONN_DEPTH];
  logic [15:0]          cwin_r  [CONN_DEPTH];
  logic [COUNT_W-1:0]   qcnt_r  [CONN_DEPTH];
  logic [SLOT_W-1:0]    qhead_r [CONN_DEPTH];

  // Table write controls
  logic                 new_we;
  logic [CONN_W-1:0]    new_idx;
  logic                 st_we, nx_we, win_we, qc_we, hd_we;
  tcprr_conn_t          st_wd;
  logic [31:0]          nx_wd;
  logic [15:0]          win_wd;
  logic [COUNT_W-1:0]   qc_wd;
  logic [SLOT_W-1:0]    hd_wd;

  // Queue RAM
  logic                 q_we;
  logic [QADDR_W-1:0]   q_waddr, q_raddr;
  logic [QENT_W-1:0]    q_wdata, q_rdata;
  logic [31:0]          q_seq;
  logic [15:0]          q_len;
  logic [TAG_WIDTH-1:0] q_tag;

  // Derived values
  logic [63:0]          key_addr;
  logic [31:0]          key_ports;
  logic [TAG_WIDTH-1:0] in_tag;
  logic                 hit;
  logic [31:0]          cur_next, top, d_geq, d_leq, d_q;
  logic [COUNT_W-1:0]   cur_cnt;
  logic [SLOT_W-1:0]    cur_head;

  tcprr_ram #(.WIDTH(QENT_W), .DEPTH(QRAM_DEPTH)) u_qram (
    .clk  (clk),
    .we   (q_we),
    .waddr(q_waddr),
    .wdata(q_wdata),
    .raddr(q_raddr),
    .rdata(q_rdata)
  );

  assign key_addr  = {in_r.source_address, in_r.dest_address};
  assign key_ports = {in_r.source_port, in_r.dest_port};
  assign in_tag    = in_r.segment_tag[TAG_WIDTH-1:0];
  assign hit       = valid_r[i_r] && (addr_r[i_r] == key_addr) && (ports_r[i_r] == key_ports);
  assign cur_next  = cnext_r[c_r];
  assign cur_cnt   = qcnt_r[c_r];
  assign cur_head  = qhead_r[c_r];
  assign top       = cur_next + {16'd0, cwin_r[c_r]} - 32'd1;
  assign d_geq     = in_r.seq_number - cur_next;
  assign d_leq     = top - in_r.seq_number;
  assign q_seq     = q_rdata[QENT_W-1 -: 32];
  assign q_len     = q_rdata[TAG_WIDTH +: 16];
  assign q_tag     = q_rdata[TAG_WIDTH-1:0];
  assign d_q       = in_r.seq_number - q_seq;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Next state and datapath
  always_comb begin
    state_nxt      = state_r;
    ret_nxt        = ret_r;
    i_nxt          = i_r;
    c_nxt          = c_r;
    free_idx_nxt   = free_idx_r;
    free_found_nxt = free_found_r;
    nxt_nxt        = nxt_r;
    ptag_nxt       = ptag_r;
    pos_nxt        = pos_r;
    j_nxt          = j_r;
    out_valid_nxt  = out_valid_r;
    out_nxt        = out_r;
    new_we  = 1'b0;
    new_idx = free_idx_r;
    st_we   = 1'b0;
    st_wd   = ST_CLOSED;
    nx_we   = 1'b0;
    nx_wd   = nxt_r;
    win_we  = 1'b0;
    win_wd  = in_r.window_size;
    qc_we   = 1'b0;
    qc_wd   = cur_cnt;
    hd_we   = 1'b0;
    hd_wd   = cur_head;
    q_we    = 1'b0;
    q_waddr = {c_r, slot_of(cur_head, j_r)};
    q_wdata = q_rdata;
    q_raddr = {c_r, cur_head};

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          i_nxt          = '0;
          free_found_nxt = 1'b0;
          state_nxt      = S_LOOKUP;
        end
      end

      // One table entry per cycle
      S_LOOKUP: begin
        if (hit) begin
          c_nxt     = i_r;
          state_nxt = S_UPDATE;
        end else begin
          if (!valid_r[i_r] && !free_found_r) begin
            free_found_nxt = 1'b1;
            free_idx_nxt   = i_r;
          end
          if (i_r == CONN_W'(CONN_DEPTH - 1)) begin
            if (free_found_r || !valid_r[i_r]) begin
              new_we    = 1'b1;
              new_idx   = free_found_r ? free_idx_r : i_r;
              c_nxt     = new_idx;
              state_nxt = S_UPDATE;
            end else begin
              out_nxt       = '{KIND_TABLE_FULL, 8'd0, 4'd0, 1'b1};
              out_valid_nxt = 1'b1;
              ret_nxt       = S_IDLE;
              state_nxt     = S_EMIT;
            end
          end else begin
            i_nxt = i_r + CONN_W'(1);
          end
        end
      end

      // Flag handling and window check
      S_UPDATE: begin
        out_nxt = '{KIND_IGNORED, 8'd0, 4'(c_r), 1'b1};
        ret_nxt = S_IDLE;
        state_nxt     = S_EMIT;
        out_valid_nxt = 1'b1;
        if (in_r.flag_syn) begin
          win_we = 1'b1;
          nx_we  = 1'b1;
          nx_wd  = in_r.seq_number + 32'd1;
          st_we  = 1'b1;
          st_wd  = in_r.flag_ack ? ST_ESTABLISHED : ST_OPENING;
        end else if (in_r.flag_fin && in_r.flag_ack) begin
          st_we = 1'b1;
          st_wd = ST_CLOSING;
        end else if (cstate_r[c_r] == ST_CLOSING) begin
          st_we = 1'b1;
          st_wd = ST_CLOSED;
        end else if (cstate_r[c_r] == ST_OPENING) begin
          nx_we = 1'b1;
          nx_wd = in_r.seq_number;
          st_we = 1'b1;
          st_wd = ST_ESTABLISHED;
        end else if (cstate_r[c_r] == ST_ESTABLISHED && in_r.payload_length != 16'd0 &&
                     !d_geq[31] && (!d_leq[31] || d_leq == 32'h8000_0000)) begin
          if (d_geq == 32'd0) begin
            nxt_nxt       = in_r.seq_number + {16'd0, in_r.payload_length};
            nx_we         = 1'b1;
            nx_wd         = nxt_nxt;
            ptag_nxt      = in_tag;
            out_valid_nxt = 1'b0;
            state_nxt     = S_DRAIN_RD;
          end else if (cur_cnt >= COUNT_W'(QUEUE_DEPTH)) begin
            out_nxt.result_kind = KIND_QUEUE_FULL;
          end else begin
            pos_nxt       = '0;
            out_valid_nxt = 1'b0;
            state_nxt     = S_FIND_RD;
          end
        end
      end

      // Delivery chain: look at the queue head
      S_DRAIN_RD: begin
        q_raddr = {c_r, cur_head};
        if (cur_cnt == '0) begin
          out_nxt = '{KIND_DELIVERED, 8'(ptag_r), 4'(c_r), 1'b1};
          out_valid_nxt = 1'b1;
          ret_nxt   = S_IDLE;
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_DRAIN_CHK;
        end
      end

      S_DRAIN_CHK: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_EMIT;
        if (q_seq == nxt_r) begin
          out_nxt  = '{KIND_DELIVERED, 8'(ptag_r), 4'(c_r), 1'b0};
          ret_nxt  = S_DRAIN_RD;
          ptag_nxt = q_tag;
          nxt_nxt  = q_seq + {16'd0, q_len};
          nx_we    = 1'b1;
          nx_wd    = nxt_nxt;
          qc_we    = 1'b1;
          qc_wd    = cur_cnt - COUNT_W'(1);
          hd_we    = 1'b1;
          hd_wd    = slot_of(cur_head, COUNT_W'(1));
        end else begin
          out_nxt = '{KIND_DELIVERED, 8'(ptag_r), 4'(c_r), 1'b1};
          ret_nxt = S_IDLE;
        end
      end

      // Sorted insert: find the position
      S_FIND_RD: begin
        q_raddr = {c_r, slot_of(cur_head, pos_r)};
        if (pos_r == cur_cnt) begin
          j_nxt     = cur_cnt;
          state_nxt = S_SHIFT_RD;
        end else begin
          state_nxt = S_FIND_CHK;
        end
      end

      S_FIND_CHK: begin
        if (!d_q[31]) begin
          pos_nxt   = pos_r + COUNT_W'(1);
          state_nxt = S_FIND_RD;
        end else begin
          j_nxt     = cur_cnt;
          state_nxt = S_SHIFT_RD;
        end
      end

      // Move the tail up one slot
      S_SHIFT_RD: begin
        q_raddr = {c_r, slot_of(cur_head, j_r - COUNT_W'(1))};
        state_nxt = (j_r == pos_r) ? S_INSERT : S_SHIFT_WR;
      end

      S_SHIFT_WR: begin
        q_we      = 1'b1;
        q_waddr   = {c_r, slot_of(cur_head, j_r)};
        q_wdata   = q_rdata;
        j_nxt     = j_r - COUNT_W'(1);
        state_nxt = S_SHIFT_RD;
      end

      S_INSERT: begin
        q_we    = 1'b1;
        q_waddr = {c_r, slot_of(cur_head, pos_r)};
        q_wdata = {in_r.seq_number, in_r.payload_length, in_tag};
        qc_we   = 1'b1;
        qc_wd   = cur_cnt + COUNT_W'(1);
        out_nxt = '{KIND_STORED, 8'd0, 4'(c_r), 1'b1};
        out_valid_nxt = 1'b1;
        ret_nxt   = S_IDLE;
        state_nxt = S_EMIT;
      end

      // Hold the result until its transfer
      S_EMIT: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          state_nxt     = ret_r;
        end
      end

      default: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int k = 0; k < CONN_DEPTH; k++) begin
        valid_r[k] <= 1'b0;
        qcnt_r[k]  <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (new_we) begin
        valid_r[new_idx] <= 1'b1;
        qcnt_r[new_idx]  <= '0;
      end
      if (qc_we) begin
        qcnt_r[c_r] <= qc_wd;
      end
    end
  end

  // Payload and table data
  always_ff @(posedge clk) begin
    ret_r        <= ret_nxt;
    i_r          <= i_nxt;
    c_r          <= c_nxt;
    free_idx_r   <= free_idx_nxt;
    free_found_r <= free_found_nxt;
    nxt_r        <= nxt_nxt;
    ptag_r       <= ptag_nxt;
    pos_r        <= pos_nxt;
    j_r          <= j_nxt;
    out_r        <= out_nxt;
    if (state_r == S_IDLE && in_valid) begin
      in_r <= in_data;
    end
    if (new_we) begin
      addr_r[new_idx]   <= key_addr;
      ports_r[new_idx]  <= key_ports;
      cstate_r[new_idx] <= ST_CLOSED;
      cnext_r[new_idx]  <= 32'd0;
      cwin_r[new_idx]   <= in_r.window_size;
      qhead_r[new_idx]  <= '0;
    end
    if (st_we) begin
      cstate_r[c_r] <= st_wd;
    end
    if (nx_we) begin
      cnext_r[c_r] <= nx_wd;
    end
    if (win_we) begin
      cwin_r[c_r] <= win_wd;
    end
    if (hd_we) begin
      qhead_r[c_r] <= hd_wd;
    end
  end

endmodule
